>>> hdl/rle_skip_frame_decoder_defines.svh
// Assertion macros shared by the frame decoder modules.
`ifndef RLE_SKIP_FRAME_DECODER_DEFINES_SVH
`define RLE_SKIP_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Check an implication on every clock edge outside reset.
`define RSFD_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check an invariant on every clock edge outside reset.
`define RSFD_ASSERT_ALWAYS(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`else

`define RSFD_ASSERT_IMPL(name, clk, rst, ante, cons, msg)
`define RSFD_ASSERT_ALWAYS(name, clk, rst, cond, msg)

`endif

`endif

>>> hdl/rsfd_pkg.sv
// Shared types and constants of the run-length frame decoder.
package rsfd_pkg;

  localparam int PosWidth   = 17;
  localparam int LenWidth   = 16;
  localparam int ColorWidth = 8;

  localparam logic [PosWidth-1:0] PosMax = '1;

  // One parsed command handed from the parser to the run unit.
  typedef struct packed {
    logic                  clr;    // frame start seen: position restarts at zero
    logic                  eof;    // terminator: end-of-frame result
    logic                  emit;   // visible write run (nonzero color and length)
    logic [LenWidth-1:0]   len;
    logic [ColorWidth-1:0] color;
  } op_t;

endpackage

>>> hdl/rsfd_front.sv
// Byte parser: turns the encoded stream into run and terminator commands.
module rsfd_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [7:0]                   code_byte,
  input  logic                         frame_start,
  output logic                         push,
  output rsfd_pkg::op_t                op
);

  typedef enum logic [2:0] {
    PhCmd,
    PhLen8,
    PhLenLo,
    PhLenHi,
    PhColor
  } phase_t;

  localparam logic [7:0] CodeEnd  = 8'd0;
  localparam logic [7:0] CodeOne  = 8'd1;
  localparam logic [7:0] CodeTwo  = 8'd2;
  localparam logic [7:0] CodeLen8 = 8'd3;

  phase_t                          phase;
  phase_t                          phase_eff;
  phase_t                          phase_next;
  logic                            frame_done;
  logic                            done_eff;
  logic                            done_next;
  logic                            clr_pending;
  logic [rsfd_pkg::LenWidth-1:0]   pending_length;
  logic [rsfd_pkg::LenWidth-1:0]   len_eff;
  logic [rsfd_pkg::LenWidth-1:0]   len_next;

  // Decode the byte against the phase, with a frame start taking effect first
  always_comb begin
    phase_eff  = frame_start ? PhCmd : phase;
    done_eff   = frame_start ? 1'b0 : frame_done;
    len_eff    = frame_start ? '0 : pending_length;
    phase_next = phase_eff;
    done_next  = done_eff;
    len_next   = len_eff;
    push       = 1'b0;
    op.clr     = frame_start | clr_pending;
    op.eof     = 1'b0;
    op.emit    = 1'b0;
    op.len     = len_eff;
    op.color   = code_byte;
    if (!done_eff) begin
      unique case (phase_eff)
        PhCmd: begin
          if (code_byte == CodeEnd) begin
            push      = 1'b1;
            op.eof    = 1'b1;
            done_next = 1'b1;
          end else if (code_byte == CodeOne) begin
            len_next   = rsfd_pkg::LenWidth'(1);
            phase_next = PhColor;
          end else if (code_byte == CodeTwo) begin
            len_next   = rsfd_pkg::LenWidth'(2);
            phase_next = PhColor;
          end else if (code_byte == CodeLen8) begin
            phase_next = PhLen8;
          end else begin
            phase_next = PhLenLo;
          end
        end
        PhLen8: begin
          len_next   = {8'd0, code_byte};
          phase_next = PhColor;
        end
        PhLenLo: begin
          len_next   = {8'd0, code_byte};
          phase_next = PhLenHi;
        end
        PhLenHi: begin
          len_next   = {code_byte, len_eff[7:0]};
          phase_next = PhColor;
        end
        PhColor: begin
          push       = 1'b1;
          op.emit    = (code_byte != 8'd0) && (len_eff != '0);
          phase_next = PhCmd;
        end
        default: begin
          phase_next = PhCmd;
        end
      endcase
    end
  end

  // Hold parser state; advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PhCmd;
      frame_done     <= 1'b1;
      clr_pending    <= 1'b0;
      pending_length <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      frame_done     <= done_next;
      pending_length <= len_next;
      clr_pending    <= push ? 1'b0 : (frame_start | clr_pending);
    end
  end

endmodule

>>> hdl/rsfd_queue.sv
// Short command queue between the parser and the run unit.
`include "rle_skip_frame_decoder_defines.svh"

module rsfd_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rsfd_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output rsfd_pkg::op_t head_op
);

  localparam int Depth    = 4;
  localparam int PtrWidth = $clog2(Depth);
  localparam int CntWidth = $clog2(Depth + 1);

  rsfd_pkg::op_t         entries [Depth];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CntWidth-1:0]   count;

  assign full      = (count == CntWidth'(Depth));
  assign not_empty = (count != '0);
  assign head_op   = entries[rd_ptr];

  // Store pushed commands
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Advance pointers and track the fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PtrWidth'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PtrWidth'(1);
      end
      if (push && !pop) begin
        count <= count + CntWidth'(1);
      end else if (pop && !push) begin
        count <= count - CntWidth'(1);
      end
    end
  end

  `RSFD_ASSERT_ALWAYS(a_no_overflow, clk, rst, !(push && full), "push into full queue")
  `RSFD_ASSERT_ALWAYS(a_no_underflow, clk, rst, !(pop && !not_empty), "pop from empty queue")
  `RSFD_ASSERT_ALWAYS(a_count_range, clk, rst, count <= CntWidth'(Depth), "queue count out of range")

endmodule

>>> hdl/rsfd_back.sv
// Run unit: tracks the pixel position and forms the result items.
`include "rle_skip_frame_decoder_defines.svh"

module rsfd_back #(
  parameter int FRAME_PIXELS = 64000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              op_valid,
  input  rsfd_pkg::op_t                     op,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rsfd_pkg::PosWidth-1:0]     run_start,
  output logic [rsfd_pkg::LenWidth-1:0]     run_length,
  output logic [rsfd_pkg::ColorWidth-1:0]   fill_color,
  output logic                              frame_end,
  output logic                              beyond_frame
);

  localparam int SumWidth = rsfd_pkg::PosWidth + 1;
  localparam logic [SumWidth-1:0] FrameLimit = SumWidth'(FRAME_PIXELS);

  logic [rsfd_pkg::PosWidth-1:0] pixel_position;
  logic [rsfd_pkg::PosWidth-1:0] base;
  logic [SumWidth-1:0]           end_pos;
  logic [rsfd_pkg::PosWidth-1:0] end_sat;
  logic                          beyond;
  logic                          result;

  // Take a command whenever the output register is free or being drained
  assign pop     = op_valid && (!out_valid || !out_stall);
  assign base    = op.clr ? '0 : pixel_position;
  assign end_pos = {1'b0, base} + SumWidth'(op.len);
  assign end_sat = end_pos[SumWidth-1] ? rsfd_pkg::PosMax : end_pos[rsfd_pkg::PosWidth-1:0];
  assign beyond  = end_pos > FrameLimit;
  assign result  = op.eof || op.emit;

  // Advance position and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_position <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        pixel_position <= op.eof ? base : end_sat;
        if (result) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (pop && result) begin
      run_start    <= base;
      run_length   <= op.eof ? '0 : op.len;
      fill_color   <= op.eof ? '0 : op.color;
      frame_end    <= op.eof;
      beyond_frame <= op.eof ? 1'b0 : beyond;
    end
  end

  `RSFD_ASSERT_IMPL(a_eof_fields, clk, rst, out_valid && frame_end, run_length == '0 && fill_color == '0 && !beyond_frame, "end-of-frame result carries run data")
  `RSFD_ASSERT_IMPL(a_run_nonempty, clk, rst, out_valid && !frame_end, run_length != '0 && fill_color != '0, "empty or skip run reported")
  `RSFD_ASSERT_IMPL(a_hold_on_stall, clk, rst, out_valid && out_stall, ##1 out_valid && $stable(run_start), "stalled result lost")

endmodule

>>> hdl/rle_skip_frame_decoder.sv
// Top level of the run-length skip frame decoder.
//
// Usage:
//   Input channel (in_valid / in_stall): one encoded byte per item, with
//   frame_start high on the first byte of a frame. Output channel
//   (out_valid / out_stall): one item per visible write run (start, length,
//   color, beyond_frame) and one end-of-frame item per terminator byte.
//   Skips and zero-length runs produce no item.
//   A result passes through the command queue and then the output register.
//   Throughput: one byte per cycle while in_stall is low; the parser, the
//   four-entry command queue and the run unit advance every cycle unless
//   held back by in_stall or out_stall.
//   in_stall rises only when the command queue is full, which happens when
//   out_stall holds back the output long enough to fill it.
//   Reset clears the parser, queue and position; bytes are then dropped until
//   one arrives with frame_start set.
module rle_skip_frame_decoder #(
  parameter int FRAME_PIXELS = 64000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        code_byte,
  input  logic                              frame_start,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rsfd_pkg::PosWidth-1:0]     run_start,
  output logic [rsfd_pkg::LenWidth-1:0]     run_length,
  output logic [rsfd_pkg::ColorWidth-1:0]   fill_color,
  output logic                              frame_end,
  output logic                              beyond_frame
);

  logic          accept;
  logic          front_push;
  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_not_empty;
  rsfd_pkg::op_t front_op;
  rsfd_pkg::op_t head_op;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept && front_push;

  rsfd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .code_byte   (code_byte),
    .frame_start (frame_start),
    .push        (front_push),
    .op          (front_op)
  );

  rsfd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  rsfd_back #(
    .FRAME_PIXELS (FRAME_PIXELS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .op_valid     (q_not_empty),
    .op           (head_op),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .run_start    (run_start),
    .run_length   (run_length),
    .fill_color   (fill_color),
    .frame_end    (frame_end),
    .beyond_frame (beyond_frame)
  );

endmodule
